// ===== src/rlr_pkg.sv =====
// ----------------------------------------------------------------------------
// rlr_pkg
// Shared types and constants for the rectangle layer rasterizer: codes,
// fixed-point settings, controller state and controller/datapath links.
// ----------------------------------------------------------------------------
package rlr_pkg;

	localparam int MAX_RECTS_DEF = 64;
	localparam int MAX_SIDE      = 300;
	localparam int FRAC_BITS     = 8;

	localparam int COORD_IN_W = 20;
	localparam int SIDE_W     = 9;
	localparam int CHAR_W     = 8;

	// Wide enough for left + width and for a pixel scaled to fixed point.
	localparam int COORD_W = ((FRAC_BITS + SIDE_W + 2) > (COORD_IN_W + 3)) ?
		(FRAC_BITS + SIDE_W + 2) : (COORD_IN_W + 3);

	localparam logic signed [COORD_W-1:0] ONE_FX = COORD_W'(1) << FRAC_BITS;

	// One table entry: filled, char, height, width, top, left.
	localparam int ENTRY_W = 1 + CHAR_W + 4 * COORD_IN_W;

	localparam logic [CHAR_W-1:0] KIND_FILLED  = 8'h52;
	localparam logic [CHAR_W-1:0] KIND_OUTLINE = 8'h72;

	localparam logic [SIDE_W-1:0] CANVAS_RESET = SIDE_W'(300);
	localparam logic [CHAR_W-1:0] BG_RESET     = CHAR_W'(32);

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		RES_OK         = 3'd0,
		RES_INVALID    = 3'd1,
		RES_FULL       = 3'd2,
		RES_ERROR      = 3'd3,
		RES_OFF_CANVAS = 3'd4
	} result_t;

	typedef enum logic [1:0] {
		REG_CANVAS_WIDTH  = 2'd0,
		REG_CANVAS_HEIGHT = 2'd1,
		REG_BACKGROUND    = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic wr_entry;
		logic err_set;
		logic scan_init;
		logic issue;
		logic reply;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_add;
		logic add_bad;
		logic add_full;
		logic query_err;
		logic query_off;
		logic table_empty;
		logic last_issue;
		logic pipe_empty;
	} dp_stat_t;

endpackage

// ===== src/rlr_ram.sv =====
// ----------------------------------------------------------------------------
// rlr_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rlr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/rlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlr_ctrl
// Sequencer for the rasterizer: accepts a command, checks it, walks the
// rectangle table for a query and triggers the result transfer.
// ----------------------------------------------------------------------------
module rlr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rlr_pkg::dp_stat_t  stat,
	output rlr_pkg::ctrl_cmd_t ctl
);

	import rlr_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.is_add || stat.query_err || stat.query_off) begin
					state_nxt = S_IDLE;
				end else if (stat.table_empty) begin
					state_nxt = S_DRAIN;
				end else begin
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.last_issue) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (stat.pipe_empty) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			S_CHECK: begin
				if (stat.is_add) begin
					ctl.reply = 1'b1;
					if (stat.add_bad || stat.add_full) begin
						ctl.err_set = 1'b1;
					end else begin
						ctl.wr_entry = 1'b1;
					end
				end else if (stat.query_err || stat.query_off) begin
					ctl.reply = 1'b1;
				end else begin
					ctl.scan_init = 1'b1;
				end
			end
			S_SCAN: begin
				ctl.issue = 1'b1;
			end
			S_DRAIN: begin
				ctl.reply = stat.pipe_empty;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== src/rlr_datapath.sv =====
// ----------------------------------------------------------------------------
// rlr_datapath
// Configuration registers, command capture, rectangle table, the scan
// pipeline that tests one rectangle per cycle, and the result registers.
// ----------------------------------------------------------------------------
module rlr_datapath #(
	parameter int MAX_RECTS = rlr_pkg::MAX_RECTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [1:0]                             wr_index,
	input  logic [rlr_pkg::SIDE_W-1:0]             wr_data,
	input  logic                                   cmd,
	input  logic [rlr_pkg::CHAR_W-1:0]             shape_kind,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_left,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_top,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_w,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_h,
	input  logic [rlr_pkg::CHAR_W-1:0]             draw_char,
	input  logic [rlr_pkg::SIDE_W-1:0]             pixel_x,
	input  logic [rlr_pkg::SIDE_W-1:0]             pixel_y,
	input  rlr_pkg::ctrl_cmd_t                     ctl,
	output rlr_pkg::dp_stat_t                      stat,
	output logic                                   done,
	output logic [rlr_pkg::CHAR_W-1:0]             pixel_char,
	output logic [2:0]                             status,
	output logic                                   end_of_row
);

	import rlr_pkg::*;

	localparam int IW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNTW = $clog2(MAX_RECTS + 1);

	// Configuration registers.
	logic [SIDE_W-1:0] canvas_width_q;
	logic [SIDE_W-1:0] canvas_height_q;
	logic [CHAR_W-1:0] background_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= CANVAS_RESET;
			canvas_height_q <= CANVAS_RESET;
			background_q    <= BG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CANVAS_WIDTH:  canvas_width_q  <= wr_data;
				REG_CANVAS_HEIGHT: canvas_height_q <= wr_data;
				REG_BACKGROUND:    background_q    <= wr_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Captured command.
	logic                         cmd_q;
	logic [CHAR_W-1:0]            kind_q;
	logic signed [COORD_IN_W-1:0] left_q;
	logic signed [COORD_IN_W-1:0] top_q;
	logic signed [COORD_IN_W-1:0] w_q;
	logic signed [COORD_IN_W-1:0] h_q;
	logic [CHAR_W-1:0]            char_q;
	logic [SIDE_W-1:0]            x_q;
	logic [SIDE_W-1:0]            y_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd;
			kind_q <= shape_kind;
			left_q <= rect_left;
			top_q  <= rect_top;
			w_q    <= rect_w;
			h_q    <= rect_h;
			char_q <= draw_char;
			x_q    <= pixel_x;
			y_q    <= pixel_y;
		end
	end

	// Table bookkeeping.
	logic [CNTW-1:0] count_q;
	logic            error_q;
	logic [IW-1:0]   idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			error_q <= 1'b0;
		end else begin
			if (ctl.wr_entry) begin
				count_q <= count_q + CNTW'(1);
			end
			if (ctl.err_set) begin
				error_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.scan_init) begin
			idx_q <= '0;
		end else if (ctl.issue) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// Command checks.
	logic kind_ok;
	logic size_ok;
	logic canvas_bad;

	assign kind_ok    = (kind_q == KIND_FILLED) || (kind_q == KIND_OUTLINE);
	assign size_ok    = !w_q[COORD_IN_W-1] && (w_q != '0) &&
	                    !h_q[COORD_IN_W-1] && (h_q != '0);
	assign canvas_bad = (canvas_width_q == '0) || (canvas_width_q > SIDE_W'(MAX_SIDE)) ||
	                    (canvas_height_q == '0) || (canvas_height_q > SIDE_W'(MAX_SIDE));

	// Rectangle table.
	logic [ENTRY_W-1:0] wentry;
	logic [ENTRY_W-1:0] rentry;

	assign wentry = {kind_q == KIND_FILLED, char_q, h_q, w_q, top_q, left_q};

	rlr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RECTS)
	) u_table (
		.clk  (clk),
		.we   (ctl.wr_entry),
		.waddr(count_q[IW-1:0]),
		.wdata(wentry),
		.raddr(idx_q),
		.rdata(rentry)
	);

	// Scan pipeline: s1 is the table read, s2 holds the rectangle bounds.
	logic v_s1;
	logic v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	logic signed [COORD_IN_W-1:0] l_s1;
	logic signed [COORD_IN_W-1:0] t_s1;
	logic signed [COORD_IN_W-1:0] w_s1;
	logic signed [COORD_IN_W-1:0] h_s1;
	logic [CHAR_W-1:0]            c_s1;
	logic                         f_s1;

	assign {f_s1, c_s1, h_s1, w_s1, t_s1, l_s1} = rentry;

	logic signed [COORD_W-1:0] l_ext;
	logic signed [COORD_W-1:0] t_ext;
	logic signed [COORD_W-1:0] w_ext;
	logic signed [COORD_W-1:0] h_ext;

	assign l_ext = COORD_W'(l_s1);
	assign t_ext = COORD_W'(t_s1);
	assign w_ext = COORD_W'(w_s1);
	assign h_ext = COORD_W'(h_s1);

	logic signed [COORD_W-1:0] l_s2;
	logic signed [COORD_W-1:0] r_s2;
	logic signed [COORD_W-1:0] t_s2;
	logic signed [COORD_W-1:0] b_s2;
	logic signed [COORD_W-1:0] lin_s2;
	logic signed [COORD_W-1:0] rin_s2;
	logic signed [COORD_W-1:0] tin_s2;
	logic signed [COORD_W-1:0] bin_s2;
	logic [CHAR_W-1:0]         c_s2;
	logic                      f_s2;

	// The inner bounds mark the edge of the border band, one unit inside.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			l_s2   <= l_ext;
			r_s2   <= l_ext + w_ext;
			t_s2   <= t_ext;
			b_s2   <= t_ext + h_ext;
			lin_s2 <= l_ext + ONE_FX;
			rin_s2 <= l_ext + w_ext - ONE_FX;
			tin_s2 <= t_ext + ONE_FX;
			bin_s2 <= t_ext + h_ext - ONE_FX;
			c_s2   <= c_s1;
			f_s2   <= f_s1;
		end
	end

	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;
	logic                      in_rect;
	logic                      border;
	logic                      hit;

	assign px      = $signed(COORD_W'(x_q) << FRAC_BITS);
	assign py      = $signed(COORD_W'(y_q) << FRAC_BITS);
	assign in_rect = (px >= l_s2) && (px <= r_s2) && (py >= t_s2) && (py <= b_s2);
	assign border  = (px < lin_s2) || (px > rin_s2) || (py < tin_s2) || (py > bin_s2);
	assign hit     = in_rect && (border || f_s2);

	// Later rectangles overwrite earlier ones.
	logic [CHAR_W-1:0] pchar_q;

	always_ff @(posedge clk) begin
		if (ctl.scan_init) begin
			pchar_q <= background_q;
		end else if (v_s2 && hit) begin
			pchar_q <= c_s2;
		end
	end

	// Status to the controller.
	always_comb begin
		stat.is_add      = (cmd_q == CMD_ADD);
		stat.add_bad     = !(kind_ok && size_ok);
		stat.add_full    = (count_q == CNTW'(MAX_RECTS));
		stat.query_err   = error_q || canvas_bad;
		stat.query_off   = (x_q >= canvas_width_q) || (y_q >= canvas_height_q);
		stat.table_empty = (count_q == '0);
		stat.last_issue  = (CNTW'(idx_q) == count_q - CNTW'(1));
		stat.pipe_empty  = !v_s1 && !v_s2;
	end

	// Result selection.
	result_t res;

	always_comb begin
		if (stat.is_add) begin
			if (stat.add_bad) begin
				res = RES_INVALID;
			end else if (stat.add_full) begin
				res = RES_FULL;
			end else begin
				res = RES_OK;
			end
		end else if (stat.query_err) begin
			res = RES_ERROR;
		end else if (stat.query_off) begin
			res = RES_OFF_CANVAS;
		end else begin
			res = RES_OK;
		end
	end

	logic query_ok;

	assign query_ok = !stat.is_add && (res == RES_OK);

	logic              done_q;
	logic [CHAR_W-1:0] pixel_char_q;
	logic [2:0]        status_q;
	logic              eor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.reply;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.reply) begin
			pixel_char_q <= query_ok ? pchar_q : '0;
			status_q     <= res;
			eor_q        <= query_ok && (x_q == canvas_width_q - SIDE_W'(1));
		end
	end

	assign done       = done_q;
	assign pixel_char = pixel_char_q;
	assign status     = status_q;
	assign end_of_row = eor_q;

endmodule

// ===== src/rectangle_layer_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// rectangle_layer_rasterizer_top
// Rectangle table with outline/fill rasterization of single pixel queries.
// ----------------------------------------------------------------------------
// Usage:
// A command is taken when start is high and busy is low. cmd selects an add
// (append one rectangle) or a pixel query. Each command gives exactly one
// result, shown on pixel_char, status and end_of_row for one cycle while done
// is high; the receiver must take it in that cycle.
// An add result is decided in the check state and then registered onto the outputs.
// A query that passes its checks walks the table, one rectangle per cycle
// through the single read port of the table memory, then waits in the drain
// state until the scan pipeline is empty before its result is registered;
// with an empty table it goes straight to the drain state. A query rejected
// by the error flag or the canvas bounds answers from the check state.
// busy stays high from the transfer until the result is produced; a new
// command may be started in the cycle that done is high.
// The register port (wr_en, wr_index, wr_data) sets canvas width, canvas
// height and background character; write it only while the block is idle.
// Reset empties the table, clears the sticky error flag and restores the
// registers to 300, 300 and a space character.
// ----------------------------------------------------------------------------
module rectangle_layer_rasterizer_top #(
	parameter int MAX_RECTS = rlr_pkg::MAX_RECTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	output logic                                   done,
	input  logic                                   wr_en,
	input  logic [1:0]                             wr_index,
	input  logic [rlr_pkg::SIDE_W-1:0]             wr_data,
	input  logic                                   cmd,
	input  logic [rlr_pkg::CHAR_W-1:0]             shape_kind,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_left,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_top,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_w,
	input  logic signed [rlr_pkg::COORD_IN_W-1:0]  rect_h,
	input  logic [rlr_pkg::CHAR_W-1:0]             draw_char,
	input  logic [rlr_pkg::SIDE_W-1:0]             pixel_x,
	input  logic [rlr_pkg::SIDE_W-1:0]             pixel_y,
	output logic [rlr_pkg::CHAR_W-1:0]             pixel_char,
	output logic [2:0]                             status,
	output logic                                   end_of_row
);

	import rlr_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	rlr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.ctl   (ctl)
	);

	rlr_datapath #(
		.MAX_RECTS(MAX_RECTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cmd       (cmd),
		.shape_kind(shape_kind),
		.rect_left (rect_left),
		.rect_top  (rect_top),
		.rect_w    (rect_w),
		.rect_h    (rect_h),
		.draw_char (draw_char),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.ctl       (ctl),
		.stat      (stat),
		.done      (done),
		.pixel_char(pixel_char),
		.status    (status),
		.end_of_row(end_of_row)
	);

endmodule
